/* src/tlbw_pkg.sv */
// package for the tlb with two-level page walk
// types, codes and constants shared by the back part, the top level and the testbench
`timescale 1ns / 1ps
package tlbw_pkg;
    localparam int DEF_TLB_ENTRIES = 64;
    localparam int PAGE_W = 20;
    localparam int ADDR_W = 32;

    localparam logic [1:0] MODE_XLATE = 2'd0;
    localparam logic [1:0] MODE_BASE  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;
    localparam logic [1:0] MODE_RDATA = 2'd3;

    localparam logic [1:0] KIND_FOUND = 2'd0;
    localparam logic [1:0] KIND_FAULT = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] read_data;
    } t_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] result_address;
        logic              writable;
    } t_result;
endpackage

/* src/tlbw_fifo.sv */
// small two-entry queue, used in front of and behind the back part
// does not use tlbw_pkg
`timescale 1ns / 1ps
module tlbw_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule

/* src/tlbw_back.sv */
// back part: tlb entries, lookup, flush and page walk sequencing
// depends on tlbw_pkg
`timescale 1ns / 1ps
module tlbw_back #(
    parameter int TLB_ENTRIES = tlbw_pkg::DEF_TLB_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlbw_pkg::t_item   i_item,
    input  logic              i_valid,
    output logic              o_take,
    output tlbw_pkg::t_result o_res,
    output logic              o_res_valid,
    input  logic              i_res_full
);
    import tlbw_pkg::*;
    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIR  = 2'd1;
    localparam logic [1:0] PH_TAB  = 2'd2;

    logic [TLB_ENTRIES-1:0] r_val;
    logic [PAGE_W-1:0]      r_vp [TLB_ENTRIES];
    logic [PAGE_W-1:0]      r_fr [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_wr;
    logic [ADDR_W-1:0]      r_base, r_pva;
    logic [1:0]             r_ph;

    logic [TLB_ENTRIES-1:0] w_hitv;
    logic                   w_hit, w_free;
    logic [IW-1:0]          w_hidx, w_fidx, w_slot;
    logic                   w_go, w_walk;
    logic [PAGE_W-1:0]      w_pg;

    assign w_pg   = i_item.address[31:12];
    assign o_take = i_valid && !i_res_full;
    assign w_go   = o_take;
    assign w_walk = (r_ph == PH_DIR) || (r_ph == PH_TAB);

    always_comb begin
        w_hit = 1'b0; w_hidx = '0; w_free = 1'b0; w_fidx = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
            w_hitv[k] = r_val[k] && (r_vp[k] == w_pg);
            if (w_hitv[k]) begin
                w_hit = 1'b1; w_hidx = IW'(k);
            end
            if (!r_val[k]) begin
                w_free = 1'b1; w_fidx = IW'(k);
            end
        end
        w_slot = w_free ? w_fidx : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val       <= '0;
            r_ph        <= PH_IDLE;
            r_base      <= '0;
            r_pva       <= '0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= 1'b0;
            if (w_go) begin
                if (w_walk) begin
                    if (i_item.mode == MODE_RDATA) begin
                        o_res_valid <= 1'b1;
                        o_res.writable <= 1'b0;
                        if (!i_item.read_data[0]) begin
                            r_ph <= PH_IDLE;
                            o_res.kind <= KIND_FAULT;
                            o_res.result_address <= '0;
                        end else if (r_ph == PH_DIR) begin
                            r_ph <= PH_TAB;
                            o_res.kind <= KIND_READ;
                            o_res.result_address <= {i_item.read_data[31:12], 12'h0}
                                + {20'h0, r_pva[21:12], 2'b00};
                        end else begin
                            r_ph <= PH_IDLE;
                            r_val[w_slot] <= 1'b1;
                            r_vp[w_slot]  <= r_pva[31:12];
                            r_fr[w_slot]  <= i_item.read_data[31:12];
                            r_wr[w_slot]  <= i_item.read_data[1];
                            o_res.kind <= KIND_FOUND;
                            o_res.result_address <= {i_item.read_data[31:12], 12'h0};
                            o_res.writable <= i_item.read_data[1];
                        end
                    end
                end else begin
                    r_ph <= PH_IDLE;
                    case (i_item.mode)
                        MODE_XLATE: begin
                            o_res_valid <= 1'b1;
                            if (w_hit) begin
                                o_res.kind <= KIND_FOUND;
                                o_res.result_address <= {r_fr[w_hidx], 12'h0};
                                o_res.writable <= r_wr[w_hidx];
                            end else begin
                                r_pva <= i_item.address;
                                r_ph  <= PH_DIR;
                                o_res.kind <= KIND_READ;
                                o_res.result_address <= r_base
                                    + {20'h0, i_item.address[31:22], 2'b00};
                                o_res.writable <= 1'b0;
                            end
                        end
                        MODE_BASE: begin
                            r_base <= i_item.address;
                            r_val  <= '0;
                        end
                        MODE_FLUSH: begin
                            if (w_hit) r_val[w_hidx] <= 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end
endmodule

/* src/tlb_with_two_level_page_walk.sv */
// tlb with two-level page walk, top level
// path: an item passes the input queue and the back part, whose registered result goes into the output queue
// throughput: one item per cycle while the result queue has room; the lookup in the back part is combinational
// a miss yields a read request; the walk continues with read-data items
// reset: synchronous active low, clears all entries, base and walk state
`timescale 1ns / 1ps
module tlb_with_two_level_page_walk #(
    parameter int TLB_ENTRIES = tlbw_pkg::DEF_TLB_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_address,
    input  logic [31:0] i_read_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [31:0] o_result_address,
    output logic        o_writable
);
    import tlbw_pkg::*;
    t_item   w_in, w_q;
    t_result w_res, w_out;
    logic    w_qempty, w_take, w_rv, w_rfull;

    assign w_in = '{mode: i_mode, address: i_address, read_data: i_read_data};

    tlbw_fifo #(.W($bits(t_item))) u_inq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(w_in),
        .o_full(full), .i_pop(w_take), .o_data(w_q), .o_empty(w_qempty)
    );

    tlbw_back #(.TLB_ENTRIES(TLB_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(w_q), .i_valid(!w_qempty),
        .o_take(w_take), .o_res(w_res), .o_res_valid(w_rv), .i_res_full(w_rfull)
    );

    // full flag is conservative: one slot kept for the result in flight
    logic w_ofull;
    tlbw_fifo #(.W($bits(t_result))) u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_rv), .i_data(w_res),
        .o_full(w_ofull), .i_pop(pop), .o_data(w_out), .o_empty(empty)
    );
    assign w_rfull = w_ofull || (w_rv && !empty && !pop);

    assign o_kind           = w_out.kind;
    assign o_result_address = w_out.result_address;
    assign o_writable       = w_out.writable;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rv |-> !w_ofull) else $error("result queue overflow");
    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_kind != 2'd3) else $error("bad result kind");
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_FAULT) |-> (o_result_address == 32'h0 && !o_writable))
        else $error("fault carries data");
endmodule

/* dv/tb_tlb_with_two_level_page_walk.sv */
// testbench for the tlb with two-level page walk: random and directed items,
// checked against a behavioural model of the buffer and the walk
// depends on tlbw_pkg and tlb_with_two_level_page_walk
`timescale 1ns / 1ps
module tb_tlb_with_two_level_page_walk;
    import tlbw_pkg::*;

    localparam int NSLOT = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_mode;
    logic [31:0] i_address;
    logic [31:0] i_read_data;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic [31:0] o_result_address;
    logic        o_writable;

    tlb_with_two_level_page_walk dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_mode(i_mode), .i_address(i_address), .i_read_data(i_read_data),
        .empty(empty), .pop(pop), .o_kind(o_kind),
        .o_result_address(o_result_address), .o_writable(o_writable)
    );

    // behavioural copy of the translation state
    logic        slot_valid [NSLOT];
    logic [19:0] slot_page [NSLOT];
    logic [19:0] slot_frame [NSLOT];
    logic        slot_wr [NSLOT];
    logic [31:0] dir_base;
    logic [1:0]  walk_state;
    logic [31:0] walk_va;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      errors = 0;
    bit      stim_done = 0;
    bit      no_idle = 0;
    int      hold_pop = 0;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic int find_slot(logic [19:0] page);
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_page[i] == page) return i;
        return -1;
    endfunction

    task automatic translate_item(t_item it);
        t_result r;
        int k;
        r = '0;
        if (walk_state == 2'd1 || walk_state == 2'd2) begin
            if (it.mode != MODE_RDATA) return;
            if (!it.read_data[0]) begin
                walk_state = 2'd0;
                r.kind = KIND_FAULT;
            end else if (walk_state == 2'd1) begin
                walk_state = 2'd2;
                r.kind = KIND_READ;
                r.result_address = {it.read_data[31:12], 12'h0} + {20'h0, walk_va[21:12], 2'b00};
            end else begin
                walk_state = 2'd0;
                k = 0;
                while (k < NSLOT && slot_valid[k]) k++;
                if (k >= NSLOT) k = 0;
                slot_valid[k] = 1'b1;
                slot_page[k] = walk_va[31:12];
                slot_frame[k] = it.read_data[31:12];
                slot_wr[k] = it.read_data[1];
                r.kind = KIND_FOUND;
                r.result_address = {it.read_data[31:12], 12'h0};
                r.writable = it.read_data[1];
            end
            expected_results.push_back(r);
            return;
        end
        walk_state = 2'd0;
        case (it.mode)
            MODE_XLATE: begin
                k = find_slot(it.address[31:12]);
                if (k >= 0) begin
                    r.kind = KIND_FOUND;
                    r.result_address = {slot_frame[k], 12'h0};
                    r.writable = slot_wr[k];
                end else begin
                    walk_va = it.address;
                    walk_state = 2'd1;
                    r.kind = KIND_READ;
                    r.result_address = dir_base + {20'h0, it.address[31:22], 2'b00};
                end
                expected_results.push_back(r);
            end
            MODE_BASE: begin
                dir_base = it.address;
                for (int i = 0; i < NSLOT; i++) begin
                    slot_valid[i] = 0; slot_page[i] = 0; slot_frame[i] = 0; slot_wr[i] = 0;
                end
            end
            MODE_FLUSH: begin
                k = find_slot(it.address[31:12]);
                if (k >= 0) begin
                    slot_valid[k] = 0; slot_page[k] = 0; slot_frame[k] = 0; slot_wr[k] = 0;
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                translate_item(pending_items.pop_front());
            end
            if ((!push || !full) && pending_items.size() > 0
                && (no_idle || $urandom_range(99) >= 13)) begin
                push <= 1'b1;
                i_mode <= pending_items[0].mode;
                i_address <= pending_items[0].address;
                i_read_data <= pending_items[0].read_data;
            end else if (!push || !full) begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d addr=%h wr=%0d",
                             $time, o_kind, o_result_address, o_writable);
                    errors++;
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (e.kind !== o_kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, e.kind, o_kind);
                        errors++;
                    end
                    if (e.result_address !== o_result_address) begin
                        $display("%0t: address expected %h actual %h",
                                 $time, e.result_address, o_result_address);
                        errors++;
                    end
                    if (e.writable !== o_writable) begin
                        $display("%0t: writable expected %0d actual %0d",
                                 $time, e.writable, o_writable);
                        errors++;
                    end
                end
            end
            if (hold_pop > 0) begin
                hold_pop <= hold_pop - 1;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || $urandom_range(99) >= 13;
            end
        end
    end

    function automatic t_item mk(logic [1:0] m, logic [31:0] a, logic [31:0] d);
        t_item it;
        it.mode = m; it.address = a; it.read_data = d;
        return it;
    endfunction

    // a translation followed by read data for a walk, with random content; the walk may fault at either level
    task automatic add_walk(logic [31:0] va);
        logic [31:0] w;
        pending_items.push_back(mk(MODE_XLATE, va, $urandom()));
        w = $urandom();
        if ($urandom_range(9) != 0) w[0] = 1'b1;
        pending_items.push_back(mk(MODE_RDATA, $urandom(), w));
        if (w[0]) begin
            w = $urandom();
            if ($urandom_range(9) != 0) w[0] = 1'b1;
            pending_items.push_back(mk(MODE_RDATA, $urandom(), w));
        end
    endtask

    initial begin
        logic [31:0] pages[8];
        i_rst_n = 1'b0;
        push = 1'b0; pop = 1'b0;
        i_mode = '0; i_address = '0; i_read_data = '0;
        dir_base = '0; walk_state = '0; walk_va = '0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_valid[i] = 0; slot_page[i] = 0; slot_frame[i] = 0; slot_wr[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stray data, walk faults, install, hit, ignore during walk, flushes
        pending_items.push_back(mk(MODE_RDATA, 32'hFFFFFFFF, 32'hFFFFFFFF));
        pending_items.push_back(mk(MODE_XLATE, 32'hFFFFFFFF, 32'h0));
        pending_items.push_back(mk(MODE_RDATA, 32'h0, 32'hFFFFFFFE));
        pending_items.push_back(mk(MODE_BASE, 32'hFFFFFFF0, 32'h0));
        pending_items.push_back(mk(MODE_XLATE, 32'hFFC01ABC, 32'h0));
        pending_items.push_back(mk(MODE_XLATE, 32'h1234, 32'h0));
        pending_items.push_back(mk(MODE_BASE, 32'h0, 32'h0));
        pending_items.push_back(mk(MODE_FLUSH, 32'h0, 32'h0));
        pending_items.push_back(mk(MODE_RDATA, 32'h0, 32'hFFFFF001));
        pending_items.push_back(mk(MODE_RDATA, 32'h0, 32'h0));
        pending_items.push_back(mk(MODE_XLATE, 32'hFFC01ABC, 32'h0));
        pending_items.push_back(mk(MODE_RDATA, 32'h0, 32'hFFFFF001));
        pending_items.push_back(mk(MODE_RDATA, 32'h0, 32'hFFFFFFFF));
        pending_items.push_back(mk(MODE_XLATE, 32'hFFC01000, 32'h0));
        pending_items.push_back(mk(MODE_FLUSH, 32'hFFC01FFF, 32'h0));
        pending_items.push_back(mk(MODE_XLATE, 32'hFFC01000, 32'h0));
        pending_items.push_back(mk(MODE_RDATA, 32'h0, 32'h00000001));
        pending_items.push_back(mk(MODE_RDATA, 32'h0, 32'h00000001));
        pending_items.push_back(mk(MODE_XLATE, 32'hFFC01000, 32'h0));

        // fill past capacity so replacement into slot 0 happens
        for (int i = 0; i < 70; i++) begin
            pending_items.push_back(mk(MODE_XLATE, {i[19:0], 12'h0} ^ 32'h5000_0000, 0));
            pending_items.push_back(mk(MODE_RDATA, 0, $urandom() | 1));
            pending_items.push_back(mk(MODE_RDATA, 0, $urandom() | 1));
        end
        while (pending_items.size() > 0) @(posedge i_clk);
        hold_pop = 60;
        for (int i = 0; i < 40; i++)
            pending_items.push_back(mk(MODE_XLATE, 32'h5000_0000 + (i << 12), 0));

        for (int i = 0; i < 8; i++) pages[i] = $urandom();
        for (int n = 0; n < 130; n++) begin
            int r;
            r = $urandom_range(99);
            if (n == 60) begin
                while (pending_items.size() > 0 || expected_results.size() > 0)
                    @(posedge i_clk);
                no_idle = 1;
            end
            if (n == 90) begin
                while (pending_items.size() > 0 || expected_results.size() > 0)
                    @(posedge i_clk);
                no_idle = 0;
            end
            if (r < 45) add_walk($urandom_range(1) ? pages[$urandom_range(7)] : $urandom());
            else if (r < 70)
                pending_items.push_back(mk(MODE_XLATE, pages[$urandom_range(7)] ^
                                           $urandom_range(4095), $urandom()));
            else if (r < 80)
                pending_items.push_back(mk(MODE_FLUSH, pages[$urandom_range(7)], $urandom()));
            else if (r < 85)
                pending_items.push_back(mk(MODE_BASE, $urandom(), $urandom()));
            else
                pending_items.push_back(mk(2'($urandom_range(3)), $urandom(), $urandom()));
        end
        while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        stim_done = 1;
    end

    always @(posedge i_clk) begin
        if (stim_done) begin
            if (errors == 0 && expected_results.size() == 0) begin
                $display("status: pass");
            end else begin
                $display("status: fail");
            end
            $finish;
        end
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end
endmodule
